[hdl/arp_cache_responder_assert.svh]
// Assertion macros shared by the ARP cache and responder RTL.
`ifndef ARP_CACHE_RESPONDER_ASSERT_SVH
`define ARP_CACHE_RESPONDER_ASSERT_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/arpc_pkg.sv]
// Types and constants of the ARP cache and responder.
package arpc_pkg;

  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;

  // Result status codes.
  localparam logic [1:0] ST_CACHED = 2'd0;
  localparam logic [1:0] ST_REPLY  = 2'd1;
  localparam logic [1:0] ST_SHORT  = 2'd2;
  localparam logic [1:0] ST_LOOKUP = 2'd3;

  // Request kinds.
  localparam logic OPC_PACKET = 1'b0;
  localparam logic OPC_LOOKUP = 1'b1;

  localparam logic [15:0] ARP_REQ_CODE     = 16'd1;
  localparam logic [10:0] MIN_PACKET_BYTES = 11'd28;

  // Configuration register indexes.
  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  // A search token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic             active;
    logic             lookup;
    logic             done;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } probe_t;

  // Direct write into a cell, used for the overwrite of slot 0.
  typedef struct packed {
    logic             en;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } cell_wr_t;

endpackage

[hdl/arpc_cell.sv]
// One cache entry of the ARP cache row, with its stage of the search token.
module arpc_cell
  import arpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  probe_t   probe_i,
  input  cell_wr_t wr_i,
  output probe_t   probe_o
);

`include "arp_cache_responder_assert.svh"

  logic             valid_r;
  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;
  probe_t           probe_r;
  probe_t           probe_nxt;
  logic             claim;
  logic             wr_en;

  always_comb begin
    // A store claims the first free entry; a lookup claims the first match.
    if (probe_i.lookup) begin
      claim = probe_i.active && !probe_i.done && valid_r && (ip_r == probe_i.ip);
    end else begin
      claim = probe_i.active && !probe_i.done && !valid_r;
    end
    probe_nxt = probe_i;
    if (claim) begin
      probe_nxt.done = 1'b1;
      if (probe_i.lookup) begin
        probe_nxt.mac = mac_r;
      end
    end
    wr_en = wr_i.en || (claim && !probe_i.lookup);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
      if (wr_en) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      ip_r  <= wr_i.ip;
      mac_r <= wr_i.mac;
    end else if (wr_en) begin
      ip_r  <= probe_i.ip;
      mac_r <= probe_i.mac;
    end
  end

  assign probe_o = probe_r;

  `ASSERT_NEXT(a_store_fills, clk, rst_n, probe_i.active && !probe_i.done && !probe_i.lookup && !valid_r, valid_r, "store passed a free entry without filling it")
  `ASSERT_NEXT(a_done_sticky, clk, rst_n, probe_i.active && probe_i.done, probe_r.done, "search token lost its done mark")
  `ASSERT_SAME(a_token_moves, clk, rst_n, probe_r.active, $past(probe_i.active), "search token appeared without an upstream token")

endmodule

[hdl/arp_cache_responder.sv]
// Top level of the ARP cache and responder: control, configuration and the cell row.
//
// The block keeps CACHE_ENTRIES IPv4-to-MAC entries in a row of cells. A request
// is accepted at a rising edge where start is high and busy is low. A request is
// either a received ARP packet (in_opcode low) or a cache lookup (in_opcode high).
// A packet shorter than the minimum ARP length is dropped; its result shows in
// the cycle after acceptance and the block stays free. Any other request launches a
// search token into the row that moves one cell per cycle: a store claims the
// first free entry, a lookup picks up the MAC of the first valid matching entry.
// If a store finds no free entry, slot 0 is overwritten when the token leaves the
// row. The result of such a request is on the out_ ports for one cycle, marked by
// out_valid, and is registered from the token as it leaves the row. Busy stays
// high until the result is shown, so one request is in work at a time. The
// receiver cannot stall: out_valid is a strobe. The configuration channel is
// always ready; register 0 is own_ip, register 1 is own_mac, which only the
// downstream reply builder needs, so the write is taken and not kept here. Reset
// clears every valid mark and the own IP; the stored addresses are left as they
// are.
module arp_cache_responder
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_opcode,
  input  logic [10:0]      in_frame_length,
  input  logic [15:0]      in_arp_operation,
  input  logic [IP_W-1:0]  in_src_ip,
  input  logic [MAC_W-1:0] in_src_mac,
  input  logic [IP_W-1:0]  in_dst_ip,
  input  logic [IP_W-1:0]  in_lookup_ip,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic             out_hit,
  output logic [MAC_W-1:0] out_found_mac,
  output logic [MAC_W-1:0] out_reply_mac,
  output logic [IP_W-1:0]  out_reply_ip,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [MAC_W-1:0] cfg_data
);

`include "arp_cache_responder_assert.svh"

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t           state_r;
  probe_t           launch_r;
  logic             reply_r;
  logic [IP_W-1:0]  own_ip_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic             out_hit_r;
  logic [MAC_W-1:0] out_found_mac_r;
  logic [MAC_W-1:0] out_reply_mac_r;
  logic [IP_W-1:0]  out_reply_ip_r;

  probe_t           chain [CACHE_ENTRIES+1];
  cell_wr_t         slot0_wr;
  logic             accept;
  logic             is_short;
  logic             reply_due;
  probe_t           chain_end;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_short  = (in_frame_length < MIN_PACKET_BYTES);
  assign reply_due = (in_arp_operation == ARP_REQ_CODE) && (in_dst_ip == own_ip_r);
  assign chain_end = chain[CACHE_ENTRIES];

  // A store that found no free entry overwrites slot 0 as the token leaves.
  always_comb begin
    slot0_wr.en  = (state_r == S_SCAN) && chain_end.active && !chain_end.lookup &&
                   !chain_end.done;
    slot0_wr.ip  = chain_end.ip;
    slot0_wr.mac = chain_end.mac;
  end

  assign chain[0] = launch_r;

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .probe_i (chain[g]),
      .wr_i    ((g == 0) ? slot0_wr : cell_wr_t'('0)),
      .probe_o (chain[g+1])
    );
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OWN_IP: begin
          own_ip_r <= cfg_data[IP_W-1:0];
        end
        CFG_OWN_MAC: begin
          // The reply's sender address is filled in downstream.
        end
        default: begin
        end
      endcase
    end
  end

  // Control sequence and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      launch_r.active <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      launch_r.active <= 1'b0;
      out_valid_r     <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            launch_r.lookup <= (in_opcode == OPC_LOOKUP);
            launch_r.done   <= 1'b0;
            reply_r         <= reply_due;
            if (in_opcode == OPC_LOOKUP) begin
              launch_r.active <= 1'b1;
              launch_r.ip     <= in_lookup_ip;
              launch_r.mac    <= '0;
              state_r         <= S_SCAN;
            end else if (is_short) begin
              // A short packet leaves the table alone.
              out_valid_r     <= 1'b1;
              out_status_r    <= ST_SHORT;
              out_hit_r       <= 1'b0;
              out_found_mac_r <= '0;
              out_reply_mac_r <= '0;
              out_reply_ip_r  <= '0;
            end else begin
              launch_r.active <= 1'b1;
              launch_r.ip     <= in_src_ip;
              launch_r.mac    <= in_src_mac;
              state_r         <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chain_end.active) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (chain_end.lookup) begin
              out_status_r    <= ST_LOOKUP;
              out_hit_r       <= chain_end.done;
              out_found_mac_r <= chain_end.done ? chain_end.mac : '0;
              out_reply_mac_r <= '0;
              out_reply_ip_r  <= '0;
            end else begin
              out_status_r    <= reply_r ? ST_REPLY : ST_CACHED;
              out_hit_r       <= 1'b0;
              out_found_mac_r <= '0;
              out_reply_mac_r <= reply_r ? chain_end.mac : '0;
              out_reply_ip_r  <= reply_r ? chain_end.ip : '0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_hit       = out_hit_r;
  assign out_found_mac = out_found_mac_r;
  assign out_reply_mac = out_reply_mac_r;
  assign out_reply_ip  = out_reply_ip_r;

  `ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid, "accepted request neither started a search nor gave a result")
  `ASSERT_SAME(a_token_in_scan, clk, rst_n, chain_end.active, state_r == S_SCAN, "search token left the row while no request was in work")
  `ASSERT_SAME(a_hit_lookup_only, clk, rst_n, out_valid && (out_status != ST_LOOKUP), !out_hit, "hit reported for a packet result")

endmodule
